### rtl/core/lbed_pkg.sv
// ----------------------------------------------------------------------------
// lbed_pkg: shared types and constants of the ladder button event detector
// Button and event codes, register indexes, configuration and record layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package lbed_pkg;

    // ADC sample width and width of the ladder threshold registers
    localparam int SAMPLE_BITS = 12;
    localparam int LEVEL_BITS  = 12;
    localparam int CMP_BITS    = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
    localparam int TIME_BITS   = 16;
    localparam int STAMP_BITS  = 32;
    localparam int NUM_BUTTONS = 7;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [STAMP_BITS-1:0] DEBOUNCE_WIN = 32'd5;

    localparam logic [LEVEL_BITS-1:0] RST_IDLE_LEVEL = 12'd3800;
    localparam logic [LEVEL_BITS-1:0] RST_A_ONE      = 12'd3100;
    localparam logic [LEVEL_BITS-1:0] RST_A_TWO      = 12'd2090;
    localparam logic [LEVEL_BITS-1:0] RST_A_THREE    = 12'd750;
    localparam logic [LEVEL_BITS-1:0] RST_B_LEVEL    = 12'd1120;
    localparam logic [TIME_BITS-1:0]  RST_LONG_PRESS = 16'd1000;
    localparam logic [TIME_BITS-1:0]  RST_REP_DELAY  = 16'd500;
    localparam logic [TIME_BITS-1:0]  RST_REP_PERIOD = 16'd150;

    typedef enum logic [2:0] {
        BTN_BACK    = 3'd0,
        BTN_CONFIRM = 3'd1,
        BTN_LEFT    = 3'd2,
        BTN_RIGHT   = 3'd3,
        BTN_UP      = 3'd4,
        BTN_DN      = 3'd5,
        BTN_POWER   = 3'd6
    } button_t;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_REPEAT  = 2'd2,
        EV_LONG    = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_IDLE_LEVEL    = 3'd0,
        REG_A_LEVEL_ONE   = 3'd1,
        REG_A_LEVEL_TWO   = 3'd2,
        REG_A_LEVEL_THREE = 3'd3,
        REG_B_LEVEL       = 3'd4,
        REG_LONG_PRESS    = 3'd5,
        REG_REPEAT_DELAY  = 3'd6,
        REG_REPEAT_PERIOD = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] idle_level;
        logic [LEVEL_BITS-1:0] a_level_one;
        logic [LEVEL_BITS-1:0] a_level_two;
        logic [LEVEL_BITS-1:0] a_level_three;
        logic [LEVEL_BITS-1:0] b_level;
        logic [TIME_BITS-1:0]  long_press_time;
        logic [TIME_BITS-1:0]  repeat_delay;
        logic [TIME_BITS-1:0]  repeat_period;
    } cfg_t;

    // per-button record kept in the state RAM
    typedef struct packed {
        logic                  last_raw;
        logic                  long_done;
        logic [STAMP_BITS-1:0] change_time;
        logic [STAMP_BITS-1:0] press_time;
        logic [STAMP_BITS-1:0] repeat_time;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    // decoded levels of one poll
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] lvl;
        logic                   a_at_idle;
        logic                   b_at_idle;
    } dec_res_t;

    // outcome of one button evaluation
    typedef struct packed {
        logic  evt;
        kind_t kind;
        logic  press;
    } eval_res_t;

endpackage

`default_nettype wire

### rtl/core/lbed_state_ram.sv
// ----------------------------------------------------------------------------
// lbed_state_ram: single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lbed_state_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/lbed_decode.sv
// ----------------------------------------------------------------------------
// lbed_decode: ladder decode and idle gating for one poll
// Turns the two ADC samples and the power pin into raw button levels.
// ----------------------------------------------------------------------------
`default_nettype none

module lbed_decode (
    input  wire logic [lbed_pkg::SAMPLE_BITS-1:0] ladder_a_sample,
    input  wire logic [lbed_pkg::SAMPLE_BITS-1:0] ladder_b_sample,
    input  wire logic                             power_pin,
    input  wire lbed_pkg::cfg_t                   cfg,
    input  wire logic [lbed_pkg::NUM_BUTTONS-1:0] held,
    input  wire logic                             a_idle_seen,
    input  wire logic                             b_idle_seen,
    output lbed_pkg::dec_res_t                    dec
);

    import lbed_pkg::*;

    logic [CMP_BITS-1:0] sa;
    logic [CMP_BITS-1:0] sb;
    button_t             ba;
    button_t             bb;

    assign sa = CMP_BITS'(ladder_a_sample);
    assign sb = CMP_BITS'(ladder_b_sample);

    // thresholds are tested in fixed order: idle, one, two, three on ladder A; idle, B level on ladder B
    always_comb
    begin
        dec = '0;
        ba  = BTN_RIGHT;
        bb  = BTN_DN;

        if (sa >= CMP_BITS'(cfg.idle_level))
        begin
            dec.a_at_idle = 1'b1;
        end
        else
        begin
            if (sa >= CMP_BITS'(cfg.a_level_one))
                ba = BTN_BACK;
            else if (sa >= CMP_BITS'(cfg.a_level_two))
                ba = BTN_CONFIRM;
            else if (sa >= CMP_BITS'(cfg.a_level_three))
                ba = BTN_LEFT;
            else
                ba = BTN_RIGHT;
            // a new button is only taken after the ladder went idle
            if (a_idle_seen || held[ba])
                dec.lvl[ba] = 1'b1;
        end

        if (sb >= CMP_BITS'(cfg.idle_level))
        begin
            dec.b_at_idle = 1'b1;
        end
        else
        begin
            if (sb >= CMP_BITS'(cfg.b_level))
                bb = BTN_UP;
            else
                bb = BTN_DN;
            if (b_idle_seen || held[bb])
                dec.lvl[bb] = 1'b1;
        end

        // power pin is active low
        dec.lvl[BTN_POWER] = ~power_pin;
    end

endmodule

`default_nettype wire

### rtl/core/lbed_button_eval.sv
// ----------------------------------------------------------------------------
// lbed_button_eval: debounce and event decision for one button record
// Read-modify step applied to the record fetched from the state RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module lbed_button_eval (
    input  wire lbed_pkg::button_t                idx,
    input  wire logic                             lvl,
    input  wire logic                             held,
    input  wire lbed_pkg::entry_t                 ent,
    input  wire logic [lbed_pkg::STAMP_BITS-1:0]  now,
    input  wire lbed_pkg::cfg_t                   cfg,
    output lbed_pkg::entry_t                      ent_next,
    output logic                                  held_next,
    output lbed_pkg::eval_res_t                   res
);

    import lbed_pkg::*;

    logic [STAMP_BITS-1:0] since_change;
    logic [STAMP_BITS-1:0] since_press;
    logic [STAMP_BITS-1:0] since_repeat;
    logic                  directional;

    assign directional = (idx inside {[BTN_LEFT:BTN_DN]});

    // all time differences wrap modulo 2^32
    assign since_press  = now - ent.press_time;
    assign since_repeat = now - ent.repeat_time;

    always_comb
    begin
        ent_next  = ent;
        held_next = held;
        res       = '0;

        // raw level change restarts the debounce window
        if (lvl != ent.last_raw)
        begin
            ent_next.change_time = now;
            ent_next.last_raw    = lvl;
        end
        since_change = now - ent_next.change_time;

        if (since_change >= DEBOUNCE_WIN)
        begin
            if (lvl && !held)
            begin
                held_next            = 1'b1;
                ent_next.press_time  = now;
                ent_next.long_done   = 1'b0;
                ent_next.repeat_time = now;
                res.evt              = 1'b1;
                res.kind             = EV_PRESS;
                res.press            = 1'b1;
            end
            else if (!lvl && held)
            begin
                held_next = 1'b0;
                res.evt   = 1'b1;
                res.kind  = EV_RELEASE;
            end
            else if (lvl)
            begin
                if (directional)
                begin
                    if (since_press >= STAMP_BITS'(cfg.repeat_delay) &&
                        since_repeat >= STAMP_BITS'(cfg.repeat_period))
                    begin
                        ent_next.repeat_time = now;
                        res.evt              = 1'b1;
                        res.kind             = EV_REPEAT;
                    end
                end
                else if (!ent.long_done && since_press >= STAMP_BITS'(cfg.long_press_time))
                begin
                    ent_next.long_done = 1'b1;
                    res.evt            = 1'b1;
                    res.kind           = EV_LONG;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/ladder_button_event_detector.sv
// ----------------------------------------------------------------------------
// ladder_button_event_detector: button events from two resistor ladders
// Debounce, idle gating, press/release, repeat and long-press per button.
// ----------------------------------------------------------------------------
// One poll at a time. A poll is taken in ST_IDLE, which also fetches the first
// button record. ST_RUN then walks the seven button records through the state
// RAM (one record a cycle unless the walk is held for the result side, read of
// the next overlapping the write-back of the current), and ST_FLUSH sends the
// final event of the poll, if there is one, marked with last_event. Events
// leave through a one-entry holding stage and an output register, so a stall
// on the result side holds the poll once it produces more than one event, or
// when the last event of the previous poll still waits in the output register.
// Configuration writes are always taken (cfg_ready is tied high) and
// must only be issued while no poll is in progress.
`default_nettype none

module ladder_button_event_detector (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // poll input
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [31:0]                         now_ms,
    input  wire logic [lbed_pkg::SAMPLE_BITS-1:0]    ladder_a_sample,
    input  wire logic [lbed_pkg::SAMPLE_BITS-1:0]    ladder_b_sample,
    input  wire logic                                power_pin,
    // event output
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output lbed_pkg::button_t                        button,
    output lbed_pkg::kind_t                          event_kind,
    output logic                                     last_event,
    // configuration
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire lbed_pkg::cfg_idx_t                  cfg_index,
    input  wire logic [lbed_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    import lbed_pkg::*;

    localparam int ADDR_BITS = $clog2(NUM_BUTTONS);

    // configuration registers
    cfg_t cfg_reg;

    // sequencer state
    state_t                 state_reg,      state_next;
    button_t                proc_idx_reg,   proc_idx_next;
    logic [STAMP_BITS-1:0]  now_reg,        now_next;
    logic [NUM_BUTTONS-1:0] lvl_reg,        lvl_next;
    logic [NUM_BUTTONS-1:0] held_reg,       held_next;
    logic [NUM_BUTTONS-1:0] vld_reg,        vld_next;
    logic                   rd_vld_reg,     rd_vld_next;
    logic                   a_idle_reg,     a_idle_next;
    logic                   b_idle_reg,     b_idle_next;

    // one-entry holding stage for the newest event of the poll
    logic                   pend_valid_reg, pend_valid_next;
    button_t                pend_button_reg, pend_button_next;
    kind_t                  pend_kind_reg,  pend_kind_next;

    // output register
    logic                   out_valid_reg,  out_valid_next;
    button_t                button_reg,     button_next;
    kind_t                  kind_reg,       kind_next;
    logic                   last_reg,       last_next;

    // RAM ports
    logic                   rd_en;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic                   wr_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [ENTRY_BITS-1:0]  rd_data;

    dec_res_t               dec;
    entry_t                 ent;
    entry_t                 ent_upd;
    logic                   held_upd;
    eval_res_t              res;
    logic                   in_xfer;
    logic                   slot_free;
    logic                   adv;

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign button     = button_reg;
    assign event_kind = kind_reg;
    assign last_event = last_reg;

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_level      <= RST_IDLE_LEVEL;
            cfg_reg.a_level_one     <= RST_A_ONE;
            cfg_reg.a_level_two     <= RST_A_TWO;
            cfg_reg.a_level_three   <= RST_A_THREE;
            cfg_reg.b_level         <= RST_B_LEVEL;
            cfg_reg.long_press_time <= RST_LONG_PRESS;
            cfg_reg.repeat_delay    <= RST_REP_DELAY;
            cfg_reg.repeat_period   <= RST_REP_PERIOD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IDLE_LEVEL:    cfg_reg.idle_level      <= cfg_data[LEVEL_BITS-1:0];
                REG_A_LEVEL_ONE:   cfg_reg.a_level_one     <= cfg_data[LEVEL_BITS-1:0];
                REG_A_LEVEL_TWO:   cfg_reg.a_level_two     <= cfg_data[LEVEL_BITS-1:0];
                REG_A_LEVEL_THREE: cfg_reg.a_level_three   <= cfg_data[LEVEL_BITS-1:0];
                REG_B_LEVEL:       cfg_reg.b_level         <= cfg_data[LEVEL_BITS-1:0];
                REG_LONG_PRESS:    cfg_reg.long_press_time <= cfg_data[TIME_BITS-1:0];
                REG_REPEAT_DELAY:  cfg_reg.repeat_delay    <= cfg_data[TIME_BITS-1:0];
                REG_REPEAT_PERIOD: cfg_reg.repeat_period   <= cfg_data[TIME_BITS-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // ladder decode of the incoming poll
    lbed_decode u_decode (
        .ladder_a_sample (ladder_a_sample),
        .ladder_b_sample (ladder_b_sample),
        .power_pin       (power_pin),
        .cfg             (cfg_reg),
        .held            (held_reg),
        .a_idle_seen     (a_idle_reg),
        .b_idle_seen     (b_idle_reg),
        .dec             (dec)
    );

    // per-button record store
    lbed_state_ram #(
        .DATA_W (ENTRY_BITS),
        .DEPTH  (NUM_BUTTONS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ent_upd),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // a record never written reads as all zero
    assign ent = rd_vld_reg ? entry_t'(rd_data) : '0;

    lbed_button_eval u_eval (
        .idx       (proc_idx_reg),
        .lvl       (lvl_reg[proc_idx_reg]),
        .held      (held_reg[proc_idx_reg]),
        .ent       (ent),
        .now       (now_reg),
        .cfg       (cfg_reg),
        .ent_next  (ent_upd),
        .held_next (held_upd),
        .res       (res)
    );

    // the walk stops only when an event must displace a held one that cannot leave
    assign slot_free = !out_valid_reg || !out_stall;
    assign adv       = !(res.evt && pend_valid_reg && !slot_free);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_reg       <= '0;
            vld_reg        <= '0;
            a_idle_reg     <= 1'b1;
            b_idle_reg     <= 1'b1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            vld_reg        <= vld_next;
            a_idle_reg     <= a_idle_next;
            b_idle_reg     <= b_idle_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        proc_idx_reg    <= proc_idx_next;
        now_reg         <= now_next;
        lvl_reg         <= lvl_next;
        rd_vld_reg      <= rd_vld_next;
        pend_button_reg <= pend_button_next;
        pend_kind_reg   <= pend_kind_next;
        button_reg      <= button_next;
        kind_reg        <= kind_next;
        last_reg        <= last_next;
    end

    // sequencer: take poll, walk records, flush last event
    always_comb
    begin
        state_next       = state_reg;
        proc_idx_next    = proc_idx_reg;
        now_next         = now_reg;
        lvl_next         = lvl_reg;
        held_next        = held_reg;
        vld_next         = vld_reg;
        rd_vld_next      = rd_vld_reg;
        a_idle_next      = a_idle_reg;
        b_idle_next      = b_idle_reg;
        pend_valid_next  = pend_valid_reg;
        pend_button_next = pend_button_reg;
        pend_kind_next   = pend_kind_reg;
        button_next      = button_reg;
        kind_next        = kind_reg;
        last_next        = last_reg;
        out_valid_next   = out_valid_reg && out_stall;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = ADDR_BITS'(proc_idx_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    now_next      = now_ms;
                    lvl_next      = dec.lvl;
                    a_idle_next   = a_idle_reg | dec.a_at_idle;
                    b_idle_next   = b_idle_reg | dec.b_at_idle;
                    rd_en         = 1'b1;
                    rd_addr       = ADDR_BITS'(BTN_BACK);
                    rd_vld_next   = vld_reg[BTN_BACK];
                    proc_idx_next = BTN_BACK;
                    state_next    = ST_RUN;
                end
            end

            ST_RUN:
            begin
                if (adv)
                begin
                    // write back the updated record
                    wr_en                  = 1'b1;
                    vld_next[proc_idx_reg] = 1'b1;
                    held_next[proc_idx_reg] = held_upd;

                    // a press closes the idle window of its ladder
                    if (res.press)
                    begin
                        if (proc_idx_reg inside {[BTN_BACK:BTN_RIGHT]})
                            a_idle_next = 1'b0;
                        else if (proc_idx_reg inside {[BTN_UP:BTN_DN]})
                            b_idle_next = 1'b0;
                    end

                    // older held event goes out, new one is held back
                    if (res.evt)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            button_next    = pend_button_reg;
                            kind_next      = pend_kind_reg;
                            last_next      = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_button_next = proc_idx_reg;
                        pend_kind_next   = res.kind;
                    end

                    if (proc_idx_reg == BTN_POWER)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        proc_idx_next = button_t'(proc_idx_reg + 3'd1);
                        rd_en         = 1'b1;
                        rd_addr       = ADDR_BITS'(proc_idx_next);
                        rd_vld_next   = vld_reg[proc_idx_next];
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    button_next     = pend_button_reg;
                    kind_next       = pend_kind_reg;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/lbed_checker.sv
// ----------------------------------------------------------------------------
// lbed_checker: port-level checks of the ladder button event detector
// Attached to the top level by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
`default_nettype none

module lbed_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic                                out_valid,
    input  wire logic                                out_stall,
    input  wire lbed_pkg::button_t                   button,
    input  wire lbed_pkg::kind_t                     event_kind,
    input  wire logic                                last_event
);

    import lbed_pkg::*;

    // a held event does not change while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(button) &&
            $stable(event_kind) && $stable(last_event))
        else $error("event changed while stalled");

    // one poll at a time: after a transfer the input is busy
    a_one_poll: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // more events of the poll still to come, so the input stays busy
    a_poll_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_event |-> in_stall)
        else $error("poll closed before its last event");

    // repeat events only for directional buttons
    a_repeat_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_REPEAT |->
            button == BTN_LEFT || button == BTN_RIGHT ||
            button == BTN_UP || button == BTN_DN)
        else $error("repeat on a non-directional button");

    // long press only for back, confirm and power
    a_long_nondir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_LONG |->
            button == BTN_BACK || button == BTN_CONFIRM || button == BTN_POWER)
        else $error("long press on a directional button");

endmodule

bind ladder_button_event_detector lbed_checker u_lbed_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .button     (button),
    .event_kind (event_kind),
    .last_event (last_event)
);

`default_nettype wire

### test/ladder_button_event_detector_tb.sv
// ----------------------------------------------------------------------------
// ladder_button_event_detector_tb: self-checking bench of the button detector
// Drives polls and register writes, with random pacing of polls and event
// stalls. A scoreboard predicts the event transfers of every accepted poll and
// checks each event leaving the block, in order and field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ladder_button_event_detector_tb;

    import lbed_pkg::*;

    localparam int NO_BTN      = 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;

    // one expected event transfer
    typedef struct packed {
        button_t btn;
        kind_t   kind;
        logic    last;
    } btn_event_t;

    // one directed poll
    typedef struct packed {
        logic [31:0]            t;
        logic [SAMPLE_BITS-1:0] a;
        logic [SAMPLE_BITS-1:0] b;
        logic                   pin;
    } poll_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the detector state and registers
    // ------------------------------------------------------------------------
    class event_scoreboard;
        logic [11:0] idle_lv, a_one, a_two, a_three, b_lv;
        logic [15:0] long_ms, rep_delay, rep_period;
        bit          held [NUM_BUTTONS];
        bit          raw_lvl [NUM_BUTTONS];
        bit          long_seen [NUM_BUTTONS];
        logic [31:0] chg_t [NUM_BUTTONS];
        logic [31:0] prs_t [NUM_BUTTONS];
        logic [31:0] rep_t [NUM_BUTTONS];
        bit          a_idle, b_idle;
        btn_event_t  pending[$];
        int          mismatches;

        function new();
            idle_lv    = RST_IDLE_LEVEL;
            a_one      = RST_A_ONE;
            a_two      = RST_A_TWO;
            a_three    = RST_A_THREE;
            b_lv       = RST_B_LEVEL;
            long_ms    = RST_LONG_PRESS;
            rep_delay  = RST_REP_DELAY;
            rep_period = RST_REP_PERIOD;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                held[i]      = 0;
                raw_lvl[i]   = 0;
                long_seen[i] = 0;
                chg_t[i]     = '0;
                prs_t[i]     = '0;
                rep_t[i]     = '0;
            end
            a_idle     = 1;
            b_idle     = 1;
            mismatches = 0;
        endfunction

        // register write; the ladder levels keep the low 12 bits
        function void write_reg(cfg_idx_t idx, logic [15:0] d);
            case (idx)
                REG_IDLE_LEVEL:    idle_lv    = d[11:0];
                REG_A_LEVEL_ONE:   a_one      = d[11:0];
                REG_A_LEVEL_TWO:   a_two      = d[11:0];
                REG_A_LEVEL_THREE: a_three    = d[11:0];
                REG_B_LEVEL:       b_lv       = d[11:0];
                REG_LONG_PRESS:    long_ms    = d;
                REG_REPEAT_DELAY:  rep_delay  = d;
                REG_REPEAT_PERIOD: rep_period = d;
                default: ;
            endcase
        endfunction

        function int decode_a(logic [11:0] s);
            if (s >= idle_lv) return NO_BTN;
            if (s >= a_one)   return BTN_BACK;
            if (s >= a_two)   return BTN_CONFIRM;
            if (s >= a_three) return BTN_LEFT;
            return BTN_RIGHT;
        endfunction

        function int decode_b(logic [11:0] s);
            if (s >= idle_lv) return NO_BTN;
            if (s >= b_lv)    return BTN_UP;
            return BTN_DN;
        endfunction

        // accepted poll: advance the state, queue the events it causes
        function void note_poll(logic [31:0] now, logic [11:0] sa, logic [11:0] sb_s,
                                logic pin);
            bit          lvl [NUM_BUTTONS];
            btn_event_t  evs [NUM_BUTTONS];
            int          n;
            int          ba;
            int          bb;
            bit          fire;
            kind_t       kd;
            logic [31:0] dur;
            n = 0;
            for (int i = 0; i < NUM_BUTTONS; i++)
                lvl[i] = 0;

            // ladder decode with idle gating
            ba = decode_a(sa);
            if (ba == NO_BTN) a_idle = 1;
            else if (a_idle || held[ba]) lvl[ba] = 1;
            bb = decode_b(sb_s);
            if (bb == NO_BTN) b_idle = 1;
            else if (b_idle || held[bb]) lvl[bb] = 1;
            lvl[BTN_POWER] = !pin;

            // per-button debounce and event rules, in button order
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                fire = 0;
                kd   = EV_PRESS;
                if (lvl[i] != raw_lvl[i]) begin
                    chg_t[i]   = now;
                    raw_lvl[i] = lvl[i];
                end
                if (32'(now - chg_t[i]) >= DEBOUNCE_WIN) begin
                    if (lvl[i] && !held[i]) begin
                        if (i <= BTN_RIGHT) a_idle = 0;
                        else if (i <= BTN_DN) b_idle = 0;
                        held[i]      = 1;
                        prs_t[i]     = now;
                        long_seen[i] = 0;
                        rep_t[i]     = now;
                        fire         = 1;
                        kd           = EV_PRESS;
                    end else if (!lvl[i] && held[i]) begin
                        held[i] = 0;
                        fire    = 1;
                        kd      = EV_RELEASE;
                    end else if (lvl[i]) begin
                        dur = now - prs_t[i];
                        if (i >= BTN_LEFT && i <= BTN_DN) begin
                            if (dur >= {16'd0, rep_delay} &&
                                32'(now - rep_t[i]) >= {16'd0, rep_period}) begin
                                rep_t[i] = now;
                                fire     = 1;
                                kd       = EV_REPEAT;
                            end
                        end else if (!long_seen[i] && dur >= {16'd0, long_ms}) begin
                            long_seen[i] = 1;
                            fire         = 1;
                            kd           = EV_LONG;
                        end
                    end
                end
                if (fire) begin
                    evs[n].btn  = button_t'(i[2:0]);
                    evs[n].kind = kd;
                    evs[n].last = 1'b0;
                    n++;
                end
            end
            if (n > 0) evs[n-1].last = 1'b1;
            for (int k = 0; k < n; k++)
                pending.push_back(evs[k]);
        endfunction

        function void note_mismatch(string what, btn_event_t want, button_t b, kind_t k,
                                    logic last);
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch (%s): expected btn=%0d kind=%0d last=%0d, ",
                          "got btn=%0d kind=%0d last=%0d"},
                         what, want.btn, want.kind, want.last, b, k, last);
        endfunction

        // accepted event transfer against the oldest expectation
        function void check_event(button_t b, kind_t k, logic last);
            btn_event_t want;
            if (pending.size() == 0) begin
                want = '0;
                note_mismatch("no event expected", want, b, k, last);
                return;
            end
            want = pending.pop_front();
            if (want.btn !== b || want.kind !== k || want.last !== last)
                note_mismatch("wrong field", want, b, k, last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [31:0]            now_ms;
    logic [SAMPLE_BITS-1:0] ladder_a_sample;
    logic [SAMPLE_BITS-1:0] ladder_b_sample;
    logic                   power_pin;
    logic                   out_valid;
    logic                   out_stall;
    button_t                button;
    kind_t                  event_kind;
    logic                   last_event;
    logic                   cfg_valid;
    logic                   cfg_ready;
    cfg_idx_t               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    event_scoreboard sb = new();
    bit              quiet = 0;
    logic [31:0]     clock_ms = '0;
    int              cycles = 0;

    ladder_button_event_detector dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .now_ms          (now_ms),
        .ladder_a_sample (ladder_a_sample),
        .ladder_b_sample (ladder_b_sample),
        .power_pin       (power_pin),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .button          (button),
        .event_kind      (event_kind),
        .last_event      (last_event),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // event monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_event(button, event_kind, last_event);
    end

    function automatic int pace();
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    // result side: random stall before each event transfer
    initial
    begin : event_sink
        int hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = pace();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // one poll transfer, then a random gap
    task automatic send_poll(logic [31:0] t, logic [11:0] sa, logic [11:0] sbv, logic pin);
        int gap;
        in_valid        <= 1'b1;
        now_ms          <= t;
        ladder_a_sample <= sa;
        ladder_b_sample <= sbv;
        power_pin       <= pin;
        do @(posedge clk); while (in_stall);
        sb.note_poll(t, sa, sbv, pin);
        gap = pace();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [15:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, d);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // levels get random upper bits, which the block drops
    task automatic set_config(logic [11:0] idle, logic [11:0] one, logic [11:0] two,
                              logic [11:0] three, logic [11:0] blv, logic [15:0] lng,
                              logic [15:0] dly, logic [15:0] per);
        write_cfg(REG_IDLE_LEVEL,    {4'($urandom_range(0, 15)), idle});
        write_cfg(REG_A_LEVEL_ONE,   {4'($urandom_range(0, 15)), one});
        write_cfg(REG_A_LEVEL_TWO,   {4'($urandom_range(0, 15)), two});
        write_cfg(REG_A_LEVEL_THREE, {4'($urandom_range(0, 15)), three});
        write_cfg(REG_B_LEVEL,       {4'($urandom_range(0, 15)), blv});
        write_cfg(REG_LONG_PRESS,    lng);
        write_cfg(REG_REPEAT_DELAY,  dly);
        write_cfg(REG_REPEAT_PERIOD, per);
    endtask

    // stop sending and wait until every expected event has come
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // sample that decodes to the wanted button, thresholds tried as candidates
    function automatic logic [11:0] pick_sample(bit on_b, int tgt);
        logic [11:0] s;
        s = $urandom_range(0, 4095);
        for (int tries = 0; tries < 64; tries++)
        begin
            if ((on_b ? sb.decode_b(s) : sb.decode_a(s)) == tgt) break;
            case ($urandom_range(0, 7))
                0: s = sb.idle_lv;
                1: s = sb.a_one;
                2: s = sb.a_two;
                3: s = sb.a_three;
                4: s = sb.b_lv;
                default: s = $urandom_range(0, 4095);
            endcase
            if ($urandom_range(0, 1)) s = s - 1'b1;
        end
        return s;
    endfunction

    // random polls: mostly held-button episodes, some bounce and noise
    task automatic run_random(int n_polls, int step_max);
        int done;
        int tgt_a;
        int tgt_b;
        bit pwr;
        bit noisy;
        int len;
        int r;
        logic [11:0] sa;
        logic [11:0] sbv;
        logic        pin;
        done = 0;
        while (done < n_polls)
        begin
            noisy = ($urandom_range(0, 9) == 0);
            tgt_a = $urandom_range(0, 6);
            if (tgt_a > BTN_RIGHT) tgt_a = NO_BTN;
            tgt_b = $urandom_range(3, 6);
            if (tgt_b < BTN_UP || tgt_b > BTN_DN) tgt_b = NO_BTN;
            pwr   = ($urandom_range(0, 2) == 0);
            len   = $urandom_range(3, 14);
            for (int k = 0; k < len && done < n_polls; k++)
            begin
                if ($urandom_range(0, 29) == 0) quiet = !quiet;
                if (noisy || $urandom_range(0, 11) == 0)
                begin
                    sa  = $urandom_range(0, 4095);
                    sbv = $urandom_range(0, 4095);
                    pin = $urandom_range(0, 1);
                end
                else
                begin
                    sa  = pick_sample(1'b0, tgt_a);
                    sbv = pick_sample(1'b1, tgt_b);
                    pin = !pwr;
                end
                r = $urandom_range(0, 39);
                if (r == 0) clock_ms = $urandom();
                else if (r == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
                else if (r < 7) clock_ms = clock_ms + $urandom_range(0, 5);
                else clock_ms = clock_ms + $urandom_range(1, step_max);
                send_poll(clock_ms, sa, sbv, pin);
                done++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        poll_t directed [$];
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        now_ms          <= '0;
        ladder_a_sample <= '1;
        ladder_b_sample <= '1;
        power_pin       <= 1'b1;
        cfg_valid       <= 1'b0;
        cfg_index       <= REG_IDLE_LEVEL;
        cfg_data        <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed polls at reset levels: debounce edge, idle gating,
        // repeats, one long press, time wrap, threshold boundaries
        directed = '{
            '{32'd0,    12'd4095, 12'd4095, 1'b1},
            '{32'd10,   12'd3500, 12'd4095, 1'b1},
            '{32'd14,   12'd3500, 12'd4095, 1'b1},
            '{32'd15,   12'd3500, 12'd4095, 1'b1},
            '{32'd20,   12'd2500, 12'd4095, 1'b1},
            '{32'd25,   12'd2500, 12'd4095, 1'b1},
            '{32'd30,   12'd3800, 12'd3800, 1'b1},
            '{32'd40,   12'd0,    12'd0,    1'b0},
            '{32'd45,   12'd0,    12'd0,    1'b0},
            '{32'd545,  12'd749,  12'd1119, 1'b0},
            '{32'd1045, 12'd0,    12'd0,    1'b0},
            '{32'd2000, 12'd0,    12'd0,    1'b0},
            '{32'd2005, 12'd3799, 12'd4095, 1'b1},
            '{32'd2010, 12'd3799, 12'd4095, 1'b1},
            '{32'd2015, 12'd3100, 12'd1120, 1'b1},
            '{32'd2020, 12'd4095, 12'd1120, 1'b1},
            '{32'd2025, 12'd3100, 12'd1120, 1'b1},
            '{32'd2030, 12'd3100, 12'd1120, 1'b1},
            '{32'hFFFF_FFF0, 12'd2090, 12'd1120, 1'b1},
            '{32'h0000_0002, 12'd750,  12'd4095, 1'b1},
            '{32'h0000_0007, 12'd4095, 12'd4095, 1'b0},
            '{32'hFFFF_FFFF, 12'd0,    12'd4095, 1'b1},
            '{32'hFFFF_FFFF, 12'd4095, 12'd4095, 1'b1}
        };
        foreach (directed[i])
            send_poll(directed[i].t, directed[i].a, directed[i].b, directed[i].pin);
        clock_ms = 32'hFFFF_FFFF;
        drain();

        // reset levels and times
        run_random(80, 150);
        drain();

        // short times, shifted levels
        set_config(12'd3600, 12'd2900, 12'd2000, 12'd900, 12'd1500, 16'd60, 16'd30, 16'd12);
        run_random(70, 15);
        drain();

        // zero times: long press and repeat on the first stable held poll
        set_config(12'd4095, 12'd3000, 12'd2000, 12'd1000, 12'd2048, 16'd0, 16'd0, 16'd0);
        run_random(60, 10);
        drain();

        // zero idle level: both ladders always idle, only power acts
        set_config(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(25, 30000);
        drain();

        // all levels at maximum, longest times
        set_config(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                   16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(35, 20000);
        drain();

        // thresholds out of order
        set_config(12'd2000, 12'd3000, 12'd500, 12'd1500, 12'd0,
                   16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
                   16'($urandom_range(0, 50)));
        run_random(60, 20);
        drain();

        // random levels and moderate times
        set_config(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 16'($urandom_range(0, 200)),
                   16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)));
        run_random(60, 60);
        drain();

        if (sb.pending.size() != 0)
        begin
            $display("%0d expected events never arrived", sb.pending.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
